### rtl/env_sensor_compensation_defines.svh
// Assertion macros shared by the compensation block.
`ifndef ENV_SENSOR_COMPENSATION_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ESC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ESC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/esc_pkg.sv
`default_nettype none
package esc_pkg;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_CAL_TEMP    = 3'd0;
   localparam logic [2:0] REG_CAL_PRESS_A = 3'd1;
   localparam logic [2:0] REG_CAL_PRESS_B = 3'd2;
   localparam logic [2:0] REG_CAL_MISC    = 3'd3;
   localparam logic [2:0] REG_CAL_HUM     = 3'd4;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   // Pipeline positions, counted in register stages after the input register.
   localparam int TF_LAT    = 4;
   localparam int TEMP_LAT  = 5;
   localparam int HUM_LAT   = 14;
   localparam int DIV_STEPS = 64;
   localparam int DIV_LAT   = DIV_STEPS + 2;
   localparam int PRESS_LAT = 19 + DIV_LAT;
   localparam int PIPE_LAT  = PRESS_LAT;

   localparam logic [31:0] HUM_MAX = 32'd419430400;

   // Decoded calibration coefficients.
   typedef struct packed {
      logic        [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic        [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
      logic        [7:0]  h1;
      logic signed [15:0] h2;
      logic        [7:0]  h3;
      logic signed [15:0] h4;
      logic signed [15:0] h5;
      logic signed [7:0]  h6;
   } cal_type;

endpackage
`default_nettype wire

### rtl/esc_req_if.sv
`default_nettype none
interface esc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] press_msb;
   logic [7:0] press_lsb;
   logic [7:0] press_xlsb;
   logic [7:0] temp_msb;
   logic [7:0] temp_lsb;
   logic [7:0] temp_xlsb;
   logic [7:0] hum_msb;
   logic [7:0] hum_lsb;

   modport source (output valid, press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb,
                   temp_xlsb, hum_msb, hum_lsb, input ready);
   modport sink (input valid, press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb,
                 temp_xlsb, hum_msb, hum_lsb, output ready);
endinterface
`default_nettype wire

### rtl/esc_rsp_if.sv
`default_nettype none
interface esc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] temperature;
   logic [31:0] pressure;
   logic [16:0] humidity;

   modport source (output valid, temperature, pressure, humidity, input ready);
   modport sink (input valid, temperature, pressure, humidity, output ready);
endinterface
`default_nettype wire

### rtl/esc_mul64.sv
`default_nettype none
module esc_mul64 import esc_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p
);
   // Low 64 bits of a 64 by 64 product from three 32 by 32 partial products.
   logic [63:0] pp0_ff, pp0_in;
   logic [31:0] pp1_ff, pp1_in;
   logic [31:0] pp2_ff, pp2_in;
   logic [63:0] p_ff;

   assign pp0_in = 64'(a[31:0]) * 64'(b[31:0]);
   assign pp1_in = a[31:0] * b[63:32];
   assign pp2_in = a[63:32] * b[31:0];

   always_ff @(posedge clock) begin
      if (en) begin
         pp0_ff <= pp0_in;
         pp1_ff <= pp1_in;
         pp2_ff <= pp2_in;
         p_ff   <= pp0_ff + {pp1_ff + pp2_ff, 32'd0};
      end
   end

   assign p = p_ff;
endmodule
`default_nettype wire

### rtl/esc_div.sv
`default_nettype none
module esc_div import esc_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic [63:0] quo,
   output logic        zero
);
   // Signed division truncating toward zero: one quotient bit per stage.
   logic [63:0] rem_ff  [0:DIV_STEPS-1];
   logic [63:0] dnum_ff [0:DIV_STEPS-1];
   logic [63:0] den_ff  [0:DIV_STEPS-1];
   logic [63:0] quo_ff  [0:DIV_STEPS];
   logic        neg_ff  [0:DIV_STEPS];
   logic        zero_ff [0:DIV_STEPS];
   logic [63:0] quo_out_ff;
   logic        zero_out_ff;

   // Setup stage takes magnitudes and remembers the quotient sign.
   always_ff @(posedge clock) begin
      if (en) begin
         dnum_ff[0] <= num[63] ? 64'd0 - num : num;
         den_ff[0]  <= den[63] ? 64'd0 - den : den;
         neg_ff[0]  <= num[63] ^ den[63];
         zero_ff[0] <= (den == 64'd0);
         rem_ff[0]  <= 64'd0;
         quo_ff[0]  <= 64'd0;
      end
   end

   // Restoring steps, most significant numerator bit first.
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [64:0] trial;
      logic [64:0] diff;
      logic        ge;

      assign trial = {rem_ff[k], dnum_ff[k][63]};
      assign diff  = trial - {1'b0, den_ff[k]};
      assign ge    = (trial >= {1'b0, den_ff[k]});

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[k+1]  <= {quo_ff[k][62:0], ge};
            neg_ff[k+1]  <= neg_ff[k];
            zero_ff[k+1] <= zero_ff[k];
         end
      end

      if (k < DIV_STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1]  <= ge ? diff[63:0] : trial[63:0];
               dnum_ff[k+1] <= {dnum_ff[k][62:0], 1'b0};
               den_ff[k+1]  <= den_ff[k];
            end
         end
      end
   end

   // Apply the sign to the quotient.
   always_ff @(posedge clock) begin
      if (en) begin
         quo_out_ff  <= neg_ff[DIV_STEPS] ? 64'd0 - quo_ff[DIV_STEPS] : quo_ff[DIV_STEPS];
         zero_out_ff <= zero_ff[DIV_STEPS];
      end
   end

   assign quo  = quo_out_ff;
   assign zero = zero_out_ff;
endmodule
`default_nettype wire

### rtl/esc_temp.sv
`default_nettype none
module esc_temp import esc_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [19:0] adc_t,
   input  cal_type     cal,
   output logic [31:0] tf,
   output logic [31:0] temp
);
   logic signed [17:0] d1_ff, d1_in;
   logic signed [16:0] e_ff, e_in;
   logic        [31:0] m1_ff, sq_ff, a_ff, b2_ff, tf_ff, temp_ff;
   logic signed [33:0] m1_full, sq_full;
   logic signed [47:0] b2_full;
   logic        [31:0] sqs, round_sum;

   // First stage: differences against T1.
   assign d1_in = $signed({1'b0, adc_t[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
   assign e_in  = $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, cal.t1});

   // Products, each registered before the next.
   assign m1_full = d1_ff * $signed(cal.t2);
   assign sq_full = e_ff * e_ff;
   assign sqs     = $signed(sq_ff) >>> 12;
   assign b2_full = $signed(sqs) * $signed(cal.t3);
   assign round_sum = tf_ff * 32'd5 + 32'd128;

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff   <= d1_in;
         e_ff    <= e_in;
         m1_ff   <= m1_full[31:0];
         sq_ff   <= sq_full[31:0];
         a_ff    <= $signed(m1_ff) >>> 11;
         b2_ff   <= b2_full[31:0];
         tf_ff   <= a_ff + 32'($signed(b2_ff) >>> 14);
         temp_ff <= $signed(round_sum) >>> 8;
      end
   end

   assign tf   = tf_ff;
   assign temp = temp_ff;
endmodule
`default_nettype wire

### rtl/esc_hum.sv
`default_nettype none
module esc_hum import esc_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] tf,
   input  logic [15:0] adc_h,
   input  cal_type     cal,
   output logic [16:0] hum
);
   logic [31:0] x_ff, m5_ff, m6_ff, m3_ff, aa_ff, pb_ff, pc_ff, bb_ff, bc_ff, bd_ff;
   logic [31:0] aa8_ff, aa9_ff, aa10_ff, xx_ff, xx12_ff, xx13_ff, sq_ff, t_ff;
   logic [15:0] adh5_ff, adh6_ff;
   logic [16:0] hum_ff;
   logic signed [47:0] m5_full;
   logic signed [39:0] m6_full;
   logic signed [40:0] m3_full;
   logic signed [47:0] bc_full;
   logic signed [40:0] t_full;
   logic [31:0] a_sum, bb_in, w, bc_sum, xx_in, s, sq_in, sqs, y;
   logic [16:0] hum_in;

   // Products with the humidity coefficients.
   assign m5_full = $signed(x_ff) * $signed(cal.h5);
   assign m6_full = $signed(x_ff) * $signed(cal.h6);
   assign m3_full = $signed(x_ff) * $signed({1'b0, cal.h3});
   assign a_sum   = {2'd0, adh6_ff, 14'd0} - {cal.h4[11:0], 20'd0} - m5_ff + 32'd16384;
   assign bb_in   = pb_ff * pc_ff;
   assign w       = 32'($signed(bb_ff) >>> 10) + 32'd2097152;
   assign bc_full = $signed(w) * $signed(cal.h2);
   assign bc_sum  = bc_ff + 32'd8192;
   assign xx_in   = aa10_ff * bd_ff;
   assign s       = $signed(xx_ff) >>> 15;
   assign sq_in   = s * s;
   assign sqs     = $signed(sq_ff) >>> 7;
   assign t_full  = $signed(sqs) * $signed({1'b0, cal.h1});

   // Final subtraction and clamp to the legal range.
   always_comb begin
      y = xx13_ff - 32'($signed(t_ff) >>> 4);
      priority if (y[31]) begin
         hum_in = 17'd0;
      end else if (y > HUM_MAX) begin
         hum_in = HUM_MAX[28:12];
      end else begin
         hum_in = y[28:12];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= tf - 32'd76800;
         adh5_ff <= adc_h;
         m5_ff   <= m5_full[31:0];
         m6_ff   <= m6_full[31:0];
         m3_ff   <= m3_full[31:0];
         adh6_ff <= adh5_ff;
         aa_ff   <= $signed(a_sum) >>> 15;
         pb_ff   <= $signed(m6_ff) >>> 10;
         pc_ff   <= 32'($signed(m3_ff) >>> 11) + 32'd32768;
         bb_ff   <= bb_in;
         aa8_ff  <= aa_ff;
         bc_ff   <= bc_full[31:0];
         aa9_ff  <= aa8_ff;
         bd_ff   <= $signed(bc_sum) >>> 14;
         aa10_ff <= aa9_ff;
         xx_ff   <= xx_in;
         sq_ff   <= sq_in;
         xx12_ff <= xx_ff;
         t_ff    <= t_full[31:0];
         xx13_ff <= xx12_ff;
         hum_ff  <= hum_in;
      end
   end

   assign hum = hum_ff;
endmodule
`default_nettype wire

### rtl/esc_press.sv
`default_nettype none
module esc_press import esc_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] tf,
   input  logic [19:0] adc_p,
   input  cal_type     cal,
   output logic [31:0] pres
);
   logic [63:0] v1_ff, sqv, m5, m2, v2a, v1b, v2_ff, v1c_ff, pm, nd_ff, nn, dv_ff;
   logic [63:0] p0_ff [1:6];
   logic [63:0] m5_d_ff [1:2];
   logic [63:0] m2_d_ff [1:2];
   logic [63:0] q, s, ps, m8, pr, sum_ff, res;
   logic [63:0] s_d_ff [1:2];
   logic [63:0] m8_d_ff [1:2];
   logic [63:0] q_d_ff [1:4];
   logic        z_d_ff [1:5];
   logic        zero;
   logic [31:0] pres_ff;

   // Offset fine temperature and pressure code complement.
   always_ff @(posedge clock) begin
      if (en) begin
         v1_ff    <= {{32{tf[31]}}, tf} - 64'd128000;
         p0_ff[1] <= 64'd1048576 - 64'(adc_p);
         for (int i = 2; i <= 6; i++) begin
            p0_ff[i] <= p0_ff[i-1];
         end
      end
   end

   // First products of the offset temperature.
   esc_mul64 u_mul_sq (.clock, .en, .a(v1_ff), .b(v1_ff), .p(sqv));
   esc_mul64 u_mul_p5 (.clock, .en, .a(v1_ff), .b(64'(cal.p5)), .p(m5));
   esc_mul64 u_mul_p2 (.clock, .en, .a(v1_ff), .b(64'(cal.p2)), .p(m2));

   // Square scaled by P6 and P3.
   esc_mul64 u_mul_p6 (.clock, .en, .a(sqv), .b(64'(cal.p6)), .p(v2a));
   esc_mul64 u_mul_p3 (.clock, .en, .a(sqv), .b(64'(cal.p3)), .p(v1b));

   always_ff @(posedge clock) begin
      if (en) begin
         m5_d_ff[1] <= m5;
         m5_d_ff[2] <= m5_d_ff[1];
         m2_d_ff[1] <= m2;
         m2_d_ff[2] <= m2_d_ff[1];
         v2_ff      <= v2a + {m5_d_ff[2][46:0], 17'd0}
                       + {{13{cal.p4[15]}}, cal.p4, 35'd0};
         v1c_ff     <= 64'($signed(v1b) >>> 8) + {m2_d_ff[2][51:0], 12'd0};
         nd_ff      <= {p0_ff[6][32:0], 31'd0} - v2_ff;
         dv_ff      <= $signed(pm) >>> 33;
      end
   end

   // Divisor and numerator of the main quotient.
   esc_mul64 u_mul_p1 (.clock, .en, .a(64'h0000_8000_0000_0000 + v1c_ff),
                       .b({48'd0, cal.p1}), .p(pm));
   esc_mul64 u_mul_k (.clock, .en, .a(nd_ff), .b(64'd3125), .p(nn));

   esc_div u_div (.clock, .en, .num(nn), .den(dv_ff), .quo(q), .zero);

   // Second-order corrections with P9 and P8.
   assign s = $signed(q) >>> 13;
   esc_mul64 u_mul_p9 (.clock, .en, .a(64'(cal.p9)), .b(s), .p(ps));
   esc_mul64 u_mul_p8 (.clock, .en, .a(64'(cal.p8)), .b(q), .p(m8));
   esc_mul64 u_mul_ss (.clock, .en, .a(ps), .b(s_d_ff[2]), .p(pr));

   assign res = 64'($signed(sum_ff) >>> 8) + {{44{cal.p7[15]}}, cal.p7, 4'd0};

   always_ff @(posedge clock) begin
      if (en) begin
         s_d_ff[1]  <= s;
         s_d_ff[2]  <= s_d_ff[1];
         m8_d_ff[1] <= m8;
         m8_d_ff[2] <= m8_d_ff[1];
         q_d_ff[1]  <= q;
         z_d_ff[1]  <= zero;
         for (int i = 2; i <= 4; i++) begin
            q_d_ff[i] <= q_d_ff[i-1];
         end
         for (int i = 2; i <= 5; i++) begin
            z_d_ff[i] <= z_d_ff[i-1];
         end
         sum_ff  <= q_d_ff[4] + 64'($signed(pr) >>> 25) + 64'($signed(m8_d_ff[2]) >>> 19);
         pres_ff <= z_d_ff[5] ? 32'd0 : res[31:0];
      end
   end

   assign pres = pres_ff;
endmodule
`default_nettype wire

### rtl/env_sensor_compensation.sv
`default_nettype none
`include "env_sensor_compensation_defines.svh"
// Channel   Direction  Handshake     Contents
// req_ch    in         valid/ready   eight raw sample bytes
// rsp_ch    out        valid/ready   temperature, pressure, humidity
// csr_*     in/out     APB           calibration registers at 8*index
//
// One transaction enters per cycle unless the pipeline is stalled; each result leaves
// in order after passing the 64 stage quotient pipeline of the divider.
// Synchronous active-high reset clears the stage valid bits and calibration.
// When a finished result is not taken, every stage holds and req_ch.ready drops.
module env_sensor_compensation import esc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   esc_req_if.sink               req_ch,
   esc_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);
   localparam int TEMP_DLY = PIPE_LAT - TEMP_LAT;
   localparam int HUM_DLY  = PIPE_LAT - HUM_LAT;

   logic [47:0] cal_temp_ff;
   logic [63:0] cal_press_a_ff, cal_press_b_ff, cal_hum_ff;
   logic [23:0] cal_misc_ff;
   logic [2:0]  csr_idx;
   logic        csr_wr;
   cal_type     cal;
   logic        pipe_en;
   logic [PIPE_LAT:0] valid_ff;
   logic [19:0] adc_p_ff [0:TF_LAT];
   logic [19:0] adc_t_ff;
   logic [15:0] adc_h_ff [0:TF_LAT];
   logic [31:0] tf, temp, pres;
   logic [16:0] hum;
   logic [31:0] temp_d_ff [1:TEMP_DLY];
   logic [16:0] hum_d_ff [1:HUM_DLY];

   // Calibration register writes.
   assign csr_idx    = csr_paddr[5:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff    <= '0;
         cal_press_a_ff <= '0;
         cal_press_b_ff <= '0;
         cal_misc_ff    <= '0;
         cal_hum_ff     <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_CAL_TEMP:    cal_temp_ff    <= csr_pwdata[47:0];
            REG_CAL_PRESS_A: cal_press_a_ff <= csr_pwdata;
            REG_CAL_PRESS_B: cal_press_b_ff <= csr_pwdata;
            REG_CAL_MISC:    cal_misc_ff    <= csr_pwdata[23:0];
            REG_CAL_HUM:     cal_hum_ff     <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      unique case (csr_idx)
         REG_CAL_TEMP:    csr_prdata = {16'd0, cal_temp_ff};
         REG_CAL_PRESS_A: csr_prdata = cal_press_a_ff;
         REG_CAL_PRESS_B: csr_prdata = cal_press_b_ff;
         REG_CAL_MISC:    csr_prdata = {40'd0, cal_misc_ff};
         REG_CAL_HUM:     csr_prdata = cal_hum_ff;
         default:         csr_prdata = '0;
      endcase
   end

   // Coefficient fields.
   always_comb begin
      cal.t1 = cal_temp_ff[15:0];
      cal.t2 = cal_temp_ff[31:16];
      cal.t3 = cal_temp_ff[47:32];
      cal.p1 = cal_press_a_ff[15:0];
      cal.p2 = cal_press_a_ff[31:16];
      cal.p3 = cal_press_a_ff[47:32];
      cal.p4 = cal_press_a_ff[63:48];
      cal.p5 = cal_press_b_ff[15:0];
      cal.p6 = cal_press_b_ff[31:16];
      cal.p7 = cal_press_b_ff[47:32];
      cal.p8 = cal_press_b_ff[63:48];
      cal.p9 = cal_misc_ff[15:0];
      cal.h6 = cal_misc_ff[23:16];
      cal.h1 = cal_hum_ff[7:0];
      cal.h2 = cal_hum_ff[23:8];
      cal.h3 = cal_hum_ff[31:24];
      cal.h4 = cal_hum_ff[47:32];
      cal.h5 = cal_hum_ff[63:48];
   end

   // The whole pipeline advances unless a finished result is waiting and not taken.
   assign pipe_en      = !valid_ff[PIPE_LAT] || rsp_ch.ready;
   assign req_ch.ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[PIPE_LAT-1:0], req_ch.valid};
      end
   end

   // Unpack the raw codes and carry them to the fine temperature stage.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         adc_p_ff[0] <= {req_ch.press_msb, req_ch.press_lsb, req_ch.press_xlsb[7:4]};
         adc_t_ff    <= {req_ch.temp_msb, req_ch.temp_lsb, req_ch.temp_xlsb[7:4]};
         adc_h_ff[0] <= {req_ch.hum_msb, req_ch.hum_lsb};
         for (int i = 1; i <= TF_LAT; i++) begin
            adc_p_ff[i] <= adc_p_ff[i-1];
            adc_h_ff[i] <= adc_h_ff[i-1];
         end
      end
   end

   esc_temp u_temp (.clock, .en(pipe_en), .adc_t(adc_t_ff), .cal, .tf, .temp);
   esc_hum u_hum (.clock, .en(pipe_en), .tf, .adc_h(adc_h_ff[TF_LAT]), .cal, .hum);
   esc_press u_press (.clock, .en(pipe_en), .tf, .adc_p(adc_p_ff[TF_LAT]), .cal, .pres);

   // Align temperature and humidity with the pressure result.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         temp_d_ff[1] <= temp;
         hum_d_ff[1]  <= hum;
         for (int i = 2; i <= TEMP_DLY; i++) begin
            temp_d_ff[i] <= temp_d_ff[i-1];
         end
         for (int i = 2; i <= HUM_DLY; i++) begin
            hum_d_ff[i] <= hum_d_ff[i-1];
         end
      end
   end

   assign rsp_ch.valid       = valid_ff[PIPE_LAT];
   assign rsp_ch.temperature = temp_d_ff[TEMP_DLY];
   assign rsp_ch.pressure    = pres;
   assign rsp_ch.humidity    = hum_d_ff[HUM_DLY];

   // Checks on the stall logic.
   `ESC_ASSERT_SAME(a_stall_blocks_input, clock, reset, rsp_ch.valid && !rsp_ch.ready, !req_ch.ready, "input taken while a result is stalled")
   `ESC_ASSERT_NEXT(a_stall_holds_valid, clock, reset, !pipe_en, $stable(valid_ff), "stage valid bits moved during a stall")
   `ESC_ASSERT_NEXT(a_accept_enters, clock, reset, req_ch.valid && req_ch.ready, valid_ff[0], "accepted transaction missing from first stage")
endmodule
`default_nettype wire

### tb/sv/tb_env_sensor_compensation.sv
`default_nettype none
module tb_env_sensor_compensation;
   import esc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 120;

   // One raw sample as it travels on the input channel.
   typedef struct {
      logic [7:0] press_msb, press_lsb, press_xlsb;
      logic [7:0] temp_msb, temp_lsb, temp_xlsb;
      logic [7:0] hum_msb, hum_lsb;
   } raw_sample_type;

   // One compensated reading.
   typedef struct {
      logic [31:0] temperature;
      logic [31:0] pressure;
      logic [16:0] humidity;
   } reading_type;

   logic clock = 1'b0;
   logic reset;

   esc_req_if req_ch ();
   esc_rsp_if rsp_ch ();

   logic                  csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   env_sensor_compensation u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch.sink),
      .rsp_ch      (rsp_ch.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Calibration copy kept by the testbench.
   logic [63:0] cal_temp, cal_press_a, cal_press_b, cal_misc, cal_hum;

   raw_sample_type pending_samples[$];
   reading_type    expected_readings[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          steady_mode = 1'b0;
   bit          req_taken = 1'b0;
   int          send_gap = 0;
   int          rsp_stall = 0;

   function automatic logic [31:0] sra32(input logic [31:0] u, input int n);
      return $signed(u) >>> n;
   endfunction

   function automatic logic [63:0] sra64(input logic [63:0] u, input int n);
      return $signed(u) >>> n;
   endfunction

   // Signed division truncating toward zero, with wrap on overflow.
   function automatic logic [63:0] div_trunc(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] an, ad, q;
      an = num[63] ? -num : num;
      ad = den[63] ? -den : den;
      q = an / ad;
      return (num[63] != den[63]) ? -q : q;
   endfunction

   // Integer compensation of one sample with the current calibration.
   function automatic reading_type compensate(input raw_sample_type s);
      reading_type r;
      logic [31:0] adc_p, adc_t, adc_h;
      logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] a, b, tf, x;
      logic [63:0] v1, v2, p, tf64;
      adc_p = {12'd0, s.press_msb, s.press_lsb, s.press_xlsb[7:4]};
      adc_t = {12'd0, s.temp_msb, s.temp_lsb, s.temp_xlsb[7:4]};
      adc_h = {16'd0, s.hum_msb, s.hum_lsb};

      t1 = {16'd0, cal_temp[15:0]};
      t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
      t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
      p1 = {48'd0, cal_press_a[15:0]};
      p2 = {{48{cal_press_a[31]}}, cal_press_a[31:16]};
      p3 = {{48{cal_press_a[47]}}, cal_press_a[47:32]};
      p4 = {{48{cal_press_a[63]}}, cal_press_a[63:48]};
      p5 = {{48{cal_press_b[15]}}, cal_press_b[15:0]};
      p6 = {{48{cal_press_b[31]}}, cal_press_b[31:16]};
      p7 = {{48{cal_press_b[47]}}, cal_press_b[47:32]};
      p8 = {{48{cal_press_b[63]}}, cal_press_b[63:48]};
      p9 = {{48{cal_misc[15]}}, cal_misc[15:0]};
      h1 = {24'd0, cal_hum[7:0]};
      h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
      h3 = {24'd0, cal_hum[31:24]};
      h4 = {{16{cal_hum[47]}}, cal_hum[47:32]};
      h5 = {{16{cal_hum[63]}}, cal_hum[63:48]};
      h6 = {{24{cal_misc[23]}}, cal_misc[23:16]};

      // Fine temperature and temperature output.
      a = sra32(((adc_t >> 3) - (t1 << 1)) * t2, 11);
      b = (adc_t >> 4) - t1;
      b = sra32(sra32(b * b, 12) * t3, 14);
      tf = a + b;
      r.temperature = sra32(tf * 32'd5 + 32'd128, 8);

      // Pressure in 64-bit arithmetic.
      tf64 = {{32{tf[31]}}, tf};
      v1 = tf64 - 64'd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
      v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
      if (v1 == 64'd0) begin
         r.pressure = 32'd0;
      end else begin
         p = 64'd1048576 - {32'd0, adc_p};
         p = div_trunc(((p << 31) - v2) * 64'd3125, v1);
         v1 = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
         v2 = sra64(p8 * p, 19);
         p = sra64(p + v1 + v2, 8) + (p7 << 4);
         r.pressure = p[31:0];
      end

      // Humidity with clamping.
      x = tf - 32'd76800;
      a = sra32((adc_h << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
      b = sra32(sra32(x * h6, 10) * (sra32(x * h3, 11) + 32'd32768), 10);
      b = sra32((b + 32'd2097152) * h2 + 32'd8192, 14);
      x = a * b;
      x = x - sra32(sra32(sra32(x, 15) * sra32(x, 15), 7) * h1, 4);
      if (x[31]) begin
         x = 32'd0;
      end
      if (x > HUM_MAX) begin
         x = HUM_MAX;
      end
      r.humidity = x[28:12];
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return $urandom_range(1, 3);
      end else if (r < 92) begin
         return $urandom_range(4, 8);
      end
      return $urandom_range(15, 45);
   endfunction

   // Driver: presents queued samples, holding each until it is taken.
   always @(negedge clock) begin
      if (!reset && (!req_ch.valid || req_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            req_ch.press_msb  <= pending_samples[0].press_msb;
            req_ch.press_lsb  <= pending_samples[0].press_lsb;
            req_ch.press_xlsb <= pending_samples[0].press_xlsb;
            req_ch.temp_msb   <= pending_samples[0].temp_msb;
            req_ch.temp_lsb   <= pending_samples[0].temp_lsb;
            req_ch.temp_xlsb  <= pending_samples[0].temp_xlsb;
            req_ch.hum_msb    <= pending_samples[0].hum_msb;
            req_ch.hum_lsb    <= pending_samples[0].hum_lsb;
            req_ch.valid      <= 1'b1;
            void'(pending_samples.pop_front());
            if (!steady_mode && $urandom_range(0, 2) == 0) begin
               send_gap = pick_gap();
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!steady_mode && $urandom_range(0, 7) == 0) begin
               rsp_stall = pick_gap();
            end
         end
      end
   end

   // Monitor: predicts on each input transaction, checks each result transaction.
   always @(posedge clock) begin
      raw_sample_type s;
      reading_type    exp_r;
      req_taken <= req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            s.press_msb  = req_ch.press_msb;
            s.press_lsb  = req_ch.press_lsb;
            s.press_xlsb = req_ch.press_xlsb;
            s.temp_msb   = req_ch.temp_msb;
            s.temp_lsb   = req_ch.temp_lsb;
            s.temp_xlsb  = req_ch.temp_xlsb;
            s.hum_msb    = req_ch.hum_msb;
            s.hum_lsb    = req_ch.hum_lsb;
            expected_readings.push_back(compensate(s));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: unexpected result transaction T=%h P=%h H=%h", $time,
                        rsp_ch.temperature, rsp_ch.pressure, rsp_ch.humidity);
               error_count++;
            end else begin
               exp_r = expected_readings.pop_front();
               if (rsp_ch.temperature !== exp_r.temperature) begin
                  $display("%0t: temperature expected %h actual %h", $time,
                           exp_r.temperature, rsp_ch.temperature);
                  error_count++;
               end
               if (rsp_ch.pressure !== exp_r.pressure) begin
                  $display("%0t: pressure expected %h actual %h", $time,
                           exp_r.pressure, rsp_ch.pressure);
                  error_count++;
               end
               if (rsp_ch.humidity !== exp_r.humidity) begin
                  $display("%0t: humidity expected %h actual %h", $time,
                           exp_r.humidity, rsp_ch.humidity);
                  error_count++;
               end
            end
         end
         // Watchdog on cycles with no transaction on either channel.
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t: watchdog expired", $time);
               $display("tb_env_sensor_compensation failed");
               $finish;
            end
         end
      end
   end

   // Register write through the APB port; the copy updates at the access edge.
   task automatic csr_write(input logic [2:0] index, input logic [63:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({index, 3'b000});
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (index)
         REG_CAL_TEMP:    cal_temp    = data & 64'h0000_FFFF_FFFF_FFFF;
         REG_CAL_PRESS_A: cal_press_a = data;
         REG_CAL_PRESS_B: cal_press_b = data;
         REG_CAL_MISC:    cal_misc    = data & 64'h0000_0000_00FF_FFFF;
         REG_CAL_HUM:     cal_hum     = data;
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_all_cal(input logic [63:0] ct, input logic [63:0] pa,
                                input logic [63:0] pb, input logic [63:0] cm,
                                input logic [63:0] ch);
      csr_write(REG_CAL_TEMP, ct);
      csr_write(REG_CAL_PRESS_A, pa);
      csr_write(REG_CAL_PRESS_B, pb);
      csr_write(REG_CAL_MISC, cm);
      csr_write(REG_CAL_HUM, ch);
   endtask

   task automatic add_sample(input logic [7:0] pm, input logic [7:0] pl, input logic [7:0] px,
                             input logic [7:0] tm, input logic [7:0] tl, input logic [7:0] tx,
                             input logic [7:0] hm, input logic [7:0] hl);
      raw_sample_type s;
      s.press_msb = pm; s.press_lsb = pl; s.press_xlsb = px;
      s.temp_msb = tm;  s.temp_lsb = tl;  s.temp_xlsb = tx;
      s.hum_msb = hm;   s.hum_lsb = hl;
      pending_samples.push_back(s);
   endtask

   // Field extremes, alternating bit patterns and ignored low nibbles.
   task automatic add_directed_samples();
      add_sample(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      add_sample(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_sample(8'hFF, 8'hFF, 8'hF0, 8'hFF, 8'hFF, 8'hF0, 8'hFF, 8'hFF);
      add_sample(8'h00, 8'h00, 8'h0F, 8'h00, 8'h00, 8'h0F, 8'h00, 8'h00);
      add_sample(8'hAA, 8'h55, 8'hA5, 8'h55, 8'hAA, 8'h5A, 8'hAA, 8'h55);
      add_sample(8'h55, 8'hAA, 8'h5A, 8'hAA, 8'h55, 8'hA5, 8'h55, 8'hAA);
      add_sample(8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00, 8'h6E, 8'h8F);
      add_sample(8'h65, 8'h5A, 8'hCF, 8'h7E, 8'hED, 8'h0F, 8'h6E, 8'h8F);
      add_sample(8'h80, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h80, 8'h00);
      add_sample(8'h7F, 8'hFF, 8'hF0, 8'h7F, 8'hFF, 8'hF0, 8'h7F, 8'hFF);
      add_sample(8'h00, 8'h00, 8'h10, 8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h01);
      add_sample(8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00, 8'h10, 8'hFF, 8'hFE);
   endtask

   task automatic add_random_samples(input int count);
      repeat (count) begin
         if ($urandom_range(0, 1) == 0) begin
            add_sample(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else begin
            // Readings near ordinary room conditions.
            add_sample(8'($urandom_range(8'h40, 8'h70)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(8'h70, 8'h90)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(8'h40, 8'h90)), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_ch.valid || expected_readings.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Typical factory calibration words, packed as the registers hold them.
   localparam logic [63:0] TYP_CAL_TEMP    = {16'h0000, 16'hFC18, 16'd26435, 16'd27504};
   localparam logic [63:0] TYP_CAL_PRESS_A = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
   localparam logic [63:0] TYP_CAL_PRESS_B = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
   localparam logic [63:0] TYP_CAL_MISC    = {40'd0, 8'd30, 16'd6000};
   localparam logic [63:0] TYP_CAL_HUM     = {16'd50, 16'd313, 8'd0, 16'd362, 8'd75};

   function automatic logic [63:0] rand_word(input logic [63:0] typical);
      logic [63:0] r;
      r = {$urandom, $urandom};
      if ($urandom_range(0, 2) != 0) begin
         return typical ^ (r & 64'h00FF_00FF_00FF_00FF);
      end
      return r;
   endfunction

   // Stimulus and phase control.
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.press_msb = '0; req_ch.press_lsb = '0; req_ch.press_xlsb = '0;
      req_ch.temp_msb = '0;  req_ch.temp_lsb = '0;  req_ch.temp_xlsb = '0;
      req_ch.hum_msb = '0;   req_ch.hum_lsb = '0;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      cal_temp = '0; cal_press_a = '0; cal_press_b = '0; cal_misc = '0; cal_hum = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset calibration gives a zero pressure divisor.
      add_directed_samples();
      wait_idle();

      // Typical calibration.
      write_all_cal(TYP_CAL_TEMP, TYP_CAL_PRESS_A, TYP_CAL_PRESS_B, TYP_CAL_MISC, TYP_CAL_HUM);
      add_directed_samples();
      wait_idle();

      // All ones everywhere; writes past the last register must change nothing.
      write_all_cal('1, '1, '1, '1, '1);
      csr_write(3'd5, {$urandom, $urandom});
      csr_write(3'd6, {$urandom, $urandom});
      csr_write(3'd7, {$urandom, $urandom});
      add_directed_samples();
      wait_idle();

      // Sign boundaries of every coefficient.
      write_all_cal(64'h8000_8000_8000_8000, 64'h8000_8000_8000_7FFF,
                    64'h8000_7FFF_8000_7FFF, 64'h0080_7FFF, 64'h8000_7FFF_FF80_00FF);
      add_directed_samples();
      wait_idle();

      // Random phases, some without any idling.
      for (int ph = 0; ph < 9; ph++) begin
         steady_mode = (ph % 3 == 1);
         write_all_cal(rand_word(TYP_CAL_TEMP), rand_word(TYP_CAL_PRESS_A),
                       rand_word(TYP_CAL_PRESS_B), rand_word(TYP_CAL_MISC),
                       rand_word(TYP_CAL_HUM));
         add_random_samples(100);
         wait_idle();
      end
      steady_mode = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_env_sensor_compensation passed");
      end else begin
         $display("tb_env_sensor_compensation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
